### design/ostb_pkg.sv
package ostb_pkg;

    // Default bank geometry, handed to the top level as parameter defaults.
    localparam int TIMER_COUNT_DEF = 16;
    localparam int PERIOD_BITS_DEF = 16;

    // Fixed widths of the item fields.
    localparam int CMD_BITS    = 3;
    localparam int INDEX_BITS  = 4;
    localparam int PERIOD_W    = 16;
    localparam int MASK_BITS   = 16;
    localparam int PRESC_BITS  = 8;

    localparam logic [PRESC_BITS-1:0] PRESCALE_RESET = 8'd100;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_TICK       = 3'd0,
        CMD_CONFIGURE  = 3'd1,
        CMD_START      = 3'd2,
        CMD_STOP       = 3'd3,
        CMD_DEINIT     = 3'd4,
        CMD_CLEAR_FLAG = 3'd5,
        CMD_QUERY      = 3'd6,
        CMD_DEINIT_ALL = 3'd7
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_START_WR,
        S_PASS,
        S_FINISH
    } t_state;

    // Outcome of one countdown step on one timer.
    typedef struct packed {
        logic active;   // timer was running and has been decremented
        logic expired;  // count reached zero on this step
    } t_step;

endpackage

### design/ostb_in_if.sv
interface ostb_in_if;
    import ostb_pkg::*;

    logic                  valid;
    logic                  ready;
    t_cmd                  cmd;
    logic [INDEX_BITS-1:0] timer_index;
    logic [PERIOD_W-1:0]   period;
    logic                  callback_enable;

    modport source (output valid, cmd, timer_index, period, callback_enable, input ready);
    modport sink   (input valid, cmd, timer_index, period, callback_enable, output ready);
endinterface

### design/ostb_out_if.sv
interface ostb_out_if;
    import ostb_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 pass_done;
    logic [MASK_BITS-1:0] expired_mask;
    logic [MASK_BITS-1:0] fire_mask;
    logic                 elapsed;

    modport source (output valid, pass_done, expired_mask, fire_mask, elapsed, input ready);
    modport sink   (input valid, pass_done, expired_mask, fire_mask, elapsed, output ready);
endinterface

### design/one_shot_timer_bank.sv
// Bank of TIMER_COUNT one-shot down-counting timers behind an 8-bit prescaler.
// Each accepted item is one command; exactly one result item comes back for it.
// A base tick advances the prescaler, and once the count reaches the
// prescale limit it returns to zero and a countdown pass walks every timer in
// turn, one timer per clock, through a single shared decrement-and-compare
// unit fed from the period and remaining-count memories. Each item goes from
// the execute state to the finish state, where the result is loaded: a pass
// walks the timers in between, start/reload adds one memory read of the
// stored period, and every other command, including a tick that does not
// complete a pass, goes straight to finish. The next item can be taken in the
// cycle after the load. The input is not ready while an item is at
// work, but a finished result sits in an output register, so the next item is
// taken while the previous result still waits downstream. Timer state is
// cleared at reset by per-timer valid bits, so there is no clearing sweep and
// the bank is usable straight out of reset. The prescale limit may be written
// only while the bank is idle; a limit of zero behaves like one. Only timers
// 0 to 15 appear in the expired and fire masks.
module one_shot_timer_bank #(
    parameter int TIMER_COUNT = ostb_pkg::TIMER_COUNT_DEF,
    parameter int PERIOD_BITS = ostb_pkg::PERIOD_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ostb_pkg::PRESC_BITS-1:0] i_cfg_wdata,
    ostb_in_if.sink                         i_cmd_ch,
    ostb_out_if.source                      o_res_ch
);
    import ostb_pkg::*;

    localparam int IW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
    localparam int CW = $clog2(TIMER_COUNT + 1);
    localparam int PB = PERIOD_BITS;

    // Sequencer state and the latched command.
    t_state                r_state, n_state;
    t_cmd                  r_cmd;
    logic [INDEX_BITS-1:0] r_idx;
    logic [PB-1:0]         r_period;
    logic                  r_cben_in;

    // Prescaler.
    logic [PRESC_BITS-1:0] r_limit;
    logic [PRESC_BITS-1:0] r_presc, n_presc;

    // Per-timer flags; valid bits stand in for zeroed memory entries.
    logic [TIMER_COUNT-1:0] r_pvld, n_pvld;
    logic [TIMER_COUNT-1:0] r_rvld, n_rvld;
    logic [TIMER_COUNT-1:0] r_flag, n_flag;
    logic [TIMER_COUNT-1:0] r_cben, n_cben;

    // Pass walker: r_cnt is the timer being read, r_proc the one being updated.
    logic [CW-1:0] r_cnt, n_cnt;
    logic [IW-1:0] r_proc;

    // Results under construction.
    logic                 r_pass, n_pass;
    logic [MASK_BITS-1:0] r_exp, n_exp;
    logic [MASK_BITS-1:0] r_fire, n_fire;

    // Output register.
    logic                 r_out_valid, n_out_valid;
    logic                 r_out_pass;
    logic [MASK_BITS-1:0] r_out_exp;
    logic [MASK_BITS-1:0] r_out_fire;
    logic                 r_out_elapsed;
    logic                 load_out;

    // Memory ports and registered read-side valid bits.
    logic [IW-1:0] raddr;
    logic          p_we, rm_we;
    logic [IW-1:0] p_waddr, rm_waddr;
    logic [PB-1:0] p_wdata, rm_wdata;
    logic [PB-1:0] p_rdata, rm_rdata;
    logic          r_pv_q, r_rv_q;
    logic [PB-1:0] per_q, rem_q;

    // Shared countdown unit.
    logic [PB-1:0] step_rem;
    t_step         step_res;

    logic          in_range;
    logic [IW-1:0] ia;
    logic [PRESC_BITS-1:0] presc_inc;

    assign ia       = IW'(r_idx);
    assign in_range = (32'(r_idx) < TIMER_COUNT);
    assign per_q    = r_pv_q ? p_rdata : '0;
    assign rem_q    = r_rv_q ? rm_rdata : '0;
    assign presc_inc = r_presc + PRESC_BITS'(1);

    ostb_ram #(.WIDTH(PB), .DEPTH(TIMER_COUNT)) u_period_ram (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (p_waddr),
        .i_wdata (p_wdata),
        .i_raddr (raddr),
        .o_rdata (p_rdata)
    );

    ostb_ram #(.WIDTH(PB), .DEPTH(TIMER_COUNT)) u_remain_ram (
        .i_clk   (i_clk),
        .i_we    (rm_we),
        .i_waddr (rm_waddr),
        .i_wdata (rm_wdata),
        .i_raddr (raddr),
        .o_rdata (rm_rdata)
    );

    ostb_step #(.PERIOD_BITS(PB)) u_step (
        .i_period    (per_q),
        .i_remaining (rem_q),
        .o_remaining (step_rem),
        .o_res       (step_res)
    );

    assign i_cmd_ch.ready = (r_state == S_IDLE);

    assign o_res_ch.valid        = r_out_valid;
    assign o_res_ch.pass_done    = r_out_pass;
    assign o_res_ch.expired_mask = r_out_exp;
    assign o_res_ch.fire_mask    = r_out_fire;
    assign o_res_ch.elapsed      = r_out_elapsed;

    // The result is loaded once the output register is free or being emptied.
    assign load_out = (r_state == S_FINISH) && (!r_out_valid || o_res_ch.ready);

    always_comb begin
        n_state  = r_state;
        n_presc  = r_presc;
        n_pvld   = r_pvld;
        n_rvld   = r_rvld;
        n_flag   = r_flag;
        n_cben   = r_cben;
        n_cnt    = r_cnt;
        n_pass   = r_pass;
        n_exp    = r_exp;
        n_fire   = r_fire;
        raddr    = IW'(r_cnt);
        p_we     = 1'b0;
        p_waddr  = ia;
        p_wdata  = r_period;
        rm_we    = 1'b0;
        rm_waddr = ia;
        rm_wdata = per_q;

        n_out_valid = r_out_valid;
        if (o_res_ch.ready) begin
            n_out_valid = 1'b0;
        end
        if (load_out) begin
            n_out_valid = 1'b1;
        end

        case (r_state)
            S_IDLE: begin
                if (i_cmd_ch.valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_pass  = 1'b0;
                n_exp   = '0;
                n_fire  = '0;
                n_state = S_FINISH;
                case (r_cmd)
                    CMD_TICK: begin
                        if (presc_inc >= r_limit) begin
                            n_presc = '0;
                            n_pass  = 1'b1;
                            n_cnt   = '0;
                            n_state = S_PASS;
                        end else begin
                            n_presc = presc_inc;
                        end
                    end
                    CMD_CONFIGURE: begin
                        if (in_range) begin
                            p_we       = 1'b1;
                            n_pvld[ia] = 1'b1;
                            n_flag[ia] = 1'b0;
                            n_cben[ia] = r_cben_in;
                        end
                    end
                    CMD_START: begin
                        raddr   = ia;
                        n_state = S_START_WR;
                    end
                    CMD_STOP: begin
                        if (in_range) begin
                            n_rvld[ia] = 1'b0;
                        end
                    end
                    CMD_DEINIT: begin
                        if (in_range) begin
                            n_pvld[ia] = 1'b0;
                            n_rvld[ia] = 1'b0;
                            n_flag[ia] = 1'b0;
                            n_cben[ia] = 1'b0;
                        end
                    end
                    CMD_CLEAR_FLAG: begin
                        if (in_range) begin
                            n_flag[ia] = 1'b0;
                        end
                    end
                    CMD_QUERY: begin
                    end
                    CMD_DEINIT_ALL: begin
                        n_pvld = '0;
                        n_rvld = '0;
                        n_flag = '0;
                        n_cben = '0;
                    end
                    default: begin
                    end
                endcase
            end
            S_START_WR: begin
                // The stored period has been read; copy it into the count.
                if (in_range) begin
                    rm_we      = 1'b1;
                    rm_wdata   = per_q;
                    n_rvld[ia] = 1'b1;
                end
                n_state = S_FINISH;
            end
            S_PASS: begin
                // Read timer r_cnt while the shared unit updates timer r_proc.
                if (r_cnt != '0) begin
                    rm_waddr = r_proc;
                    rm_wdata = step_rem;
                    rm_we    = step_res.active;
                    if (step_res.expired) begin
                        n_flag[r_proc] = 1'b1;
                        if (32'(r_proc) < MASK_BITS) begin
                            n_exp = r_exp | (MASK_BITS'(1) << r_proc);
                            if (r_cben[r_proc]) begin
                                n_fire = r_fire | (MASK_BITS'(1) << r_proc);
                            end
                        end
                    end
                end
                if (r_cnt == CW'(TIMER_COUNT)) begin
                    n_state = S_FINISH;
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end
            S_FINISH: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_limit     <= PRESCALE_RESET;
            r_presc     <= '0;
            r_pvld      <= '0;
            r_rvld      <= '0;
            r_flag      <= '0;
            r_cben      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_presc     <= n_presc;
            r_pvld      <= n_pvld;
            r_rvld      <= n_rvld;
            r_flag      <= n_flag;
            r_cben      <= n_cben;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd_ch.valid && i_cmd_ch.ready) begin
            r_cmd     <= i_cmd_ch.cmd;
            r_idx     <= i_cmd_ch.timer_index;
            r_period  <= PB'(i_cmd_ch.period);
            r_cben_in <= i_cmd_ch.callback_enable;
        end
        r_pass <= n_pass;
        r_exp  <= n_exp;
        r_fire <= n_fire;
        r_proc <= raddr;
        r_pv_q <= r_pvld[raddr];
        r_rv_q <= r_rvld[raddr];
        if (load_out) begin
            r_out_pass    <= r_pass;
            r_out_exp     <= r_exp;
            r_out_fire    <= r_fire;
            r_out_elapsed <= in_range && r_flag[ia];
        end
    end

    // A timer can only fire if it has expired in the same pass.
    a_fire_subset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out_fire & ~r_out_exp) == '0))
        else $error("fire mask holds a timer that did not expire");

    // A freshly loaded pass result means the prescaler has just restarted.
    a_pass_presc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load_out && r_pass) |=> (r_presc == '0))
        else $error("pass reported without prescaler restart");

    // The walker never runs past the last timer and always ends in FINISH.
    a_pass_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PASS) |=> ((r_state == S_PASS && r_cnt <= CW'(TIMER_COUNT))
                                 || r_state == S_FINISH))
        else $error("countdown pass walker out of range");

    // Masks stay clear for any item that did not run a pass.
    a_mask_nopass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load_out && !r_pass) |=> (r_out_exp == '0 && r_out_fire == '0))
        else $error("mask reported without a pass");
endmodule

### design/ostb_ram.sv
module ostb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### design/ostb_step.sv
module ostb_step #(
    parameter int PERIOD_BITS = 16
) (
    input  logic [PERIOD_BITS-1:0] i_period,
    input  logic [PERIOD_BITS-1:0] i_remaining,
    output logic [PERIOD_BITS-1:0] o_remaining,
    output ostb_pkg::t_step        o_res
);
    import ostb_pkg::*;

    // A timer counts only while it has a period and time left to run.
    always_comb begin
        o_res.active  = (i_period != '0) && (i_remaining != '0);
        o_remaining   = i_remaining - PERIOD_BITS'(1);
        o_res.expired = o_res.active && (o_remaining == '0);
    end
endmodule

### dv/timer_bank_check.sv
module timer_bank_check (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ostb_pkg::PRESC_BITS-1:0] i_cfg_wdata,
    ostb_in_if                              cmd_ch,
    ostb_out_if                             res_ch,
    output int                              o_fail_count,
    output int                              o_pending,
    output int                              o_checked,
    output int                              o_passes,
    output int                              o_expiries
);
    import ostb_pkg::*;

    localparam int N_TIMERS   = TIMER_COUNT_DEF;
    localparam int PRINT_CAP  = 100;

    typedef struct packed {
        logic                 pass_done;
        logic [MASK_BITS-1:0] expired_mask;
        logic [MASK_BITS-1:0] fire_mask;
        logic                 elapsed;
    } timer_result_t;

    // Shadow copy of the bank.
    logic [PRESC_BITS-1:0] tick_limit;
    logic [PRESC_BITS-1:0] tick_count;
    logic [PERIOD_W-1:0]   period_mem [N_TIMERS];
    logic [PERIOD_W-1:0]   remain_mem [N_TIMERS];
    logic                  elapsed_mem[N_TIMERS];
    logic                  cb_mem     [N_TIMERS];

    timer_result_t expected_results[$];

    function automatic void clear_timer(int t);
        period_mem[t]  = '0;
        remain_mem[t]  = '0;
        elapsed_mem[t] = 1'b0;
        cb_mem[t]      = 1'b0;
    endfunction

    // Applies one command to the shadow bank and returns what the block must answer.
    function automatic timer_result_t advance_bank(t_cmd c, logic [INDEX_BITS-1:0] idx,
                                                  logic [PERIOD_W-1:0] per, logic cb);
        timer_result_t r;
        int t;
        r = '0;
        case (c)
            CMD_TICK: begin
                tick_count = tick_count + 1'b1;
                if (tick_count >= tick_limit) begin
                    tick_count  = '0;
                    r.pass_done = 1'b1;
                    for (t = 0; t < N_TIMERS; t++) begin
                        if (period_mem[t] != '0 && remain_mem[t] != '0) begin
                            remain_mem[t] = remain_mem[t] - 1'b1;
                            if (remain_mem[t] == '0) begin
                                elapsed_mem[t]    = 1'b1;
                                r.expired_mask[t] = 1'b1;
                                r.fire_mask[t]    = cb_mem[t];
                            end
                        end
                    end
                end
            end
            CMD_CONFIGURE: begin
                period_mem[idx]  = per;
                elapsed_mem[idx] = 1'b0;
                cb_mem[idx]      = cb;
            end
            CMD_START:      remain_mem[idx] = period_mem[idx];
            CMD_STOP:       remain_mem[idx] = '0;
            CMD_DEINIT:     clear_timer(int'(idx));
            CMD_CLEAR_FLAG: elapsed_mem[idx] = 1'b0;
            CMD_DEINIT_ALL: begin
                for (t = 0; t < N_TIMERS; t++) clear_timer(t);
            end
            default: ;
        endcase
        r.elapsed = elapsed_mem[idx];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [MASK_BITS-1:0] got,
                                   logic [MASK_BITS-1:0] want);
        // Printing is capped so that a broken build cannot flood the log.
        if (o_fail_count < PRINT_CAP) begin
            $display("mismatch at result %0d, %s: got %h, expected %h",
                     o_checked, what, got, want);
        end
        o_fail_count++;
    endtask

    task automatic check_result();
        timer_result_t want;
        if (expected_results.size() == 0) begin
            report_mismatch("result with no command outstanding", res_ch.expired_mask, '0);
        end else begin
            want = expected_results.pop_front();
            if (res_ch.pass_done !== want.pass_done)
                report_mismatch("pass_done", MASK_BITS'(res_ch.pass_done),
                                MASK_BITS'(want.pass_done));
            if (res_ch.expired_mask !== want.expired_mask)
                report_mismatch("expired_mask", res_ch.expired_mask, want.expired_mask);
            if (res_ch.fire_mask !== want.fire_mask)
                report_mismatch("fire_mask", res_ch.fire_mask, want.fire_mask);
            if (res_ch.elapsed !== want.elapsed)
                report_mismatch("elapsed", MASK_BITS'(res_ch.elapsed),
                                MASK_BITS'(want.elapsed));
            o_passes   += int'(want.pass_done);
            o_expiries += $countones(want.expired_mask);
        end
        o_checked++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tick_limit = PRESCALE_RESET;
            tick_count = '0;
            for (int t = 0; t < N_TIMERS; t++) clear_timer(t);
            expected_results.delete();
            o_fail_count = 0;
            o_checked    = 0;
            o_passes     = 0;
            o_expiries   = 0;
        end else begin
            if (i_cfg_we) tick_limit = i_cfg_wdata;
            // A result can never belong to the command taken at the same edge.
            if (res_ch.valid && res_ch.ready) check_result();
            if (cmd_ch.valid && cmd_ch.ready) begin
                expected_results.push_back(advance_bank(cmd_ch.cmd, cmd_ch.timer_index,
                                                        cmd_ch.period,
                                                        cmd_ch.callback_enable));
            end
        end
        o_pending = expected_results.size();
    end

endmodule

### dv/tb.sv
module tb;
    import ostb_pkg::*;

    // Timeout, in cycles: far beyond the slowest legal run of this stimulus.
    localparam int TIMEOUT_CYCLES = 400000;
    localparam int CLK_PERIOD     = 12;
    // Cycles left after the last result so that any stray result would show up.
    localparam int DRAIN_CYCLES   = 40;
    localparam int HOLD_CYCLES    = 300;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [PRESC_BITS-1:0] cfg_wdata = '0;

    ostb_in_if  cmd_ch();
    ostb_out_if res_ch();

    int fail_count;
    int pending;
    int checked;
    int passes;
    int expiries;

    // Percentages that shape the traffic on each side, and the length of a
    // deliberate hold-off on the result side, counted down by the receiver.
    int sender_idle_pct = 0;
    int stall_pct = 0;
    int hold_left = 0;

    one_shot_timer_bank uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_cmd_ch    (cmd_ch),
        .o_res_ch    (res_ch)
    );

    timer_bank_check u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .cmd_ch       (cmd_ch),
        .res_ch       (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_passes     (passes),
        .o_expiries   (expiries)
    );

    always begin
        #(CLK_PERIOD / 2) i_clk = 1'b1;
        #(CLK_PERIOD / 2) i_clk = 1'b0;
    end

    // Offers one item, after a random number of idle cycles, and returns at the
    // rising edge at which the block takes it. Valid stays high on return, so
    // back-to-back items never see it dropped and raised within one time step.
    task automatic send_item(t_cmd c, logic [INDEX_BITS-1:0] idx,
                             logic [PERIOD_W-1:0] per, logic cb);
        int gap;
        gap = 0;
        while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) gap++;
        @(negedge i_clk);
        if (gap > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cmd_ch.valid           <= 1'b1;
        cmd_ch.cmd             <= c;
        cmd_ch.timer_index     <= idx;
        cmd_ch.period          <= per;
        cmd_ch.callback_enable <= cb;
        do @(posedge i_clk); while (!cmd_ch.ready);
    endtask

    // Random command mix. Ticks dominate so that timers actually run down, and
    // periods are mostly short so that expiries are frequent; the rest of the
    // periods cover the full 16-bit range and the inactive value of zero.
    // Fields that a command ignores still carry random noise.
    task automatic send_random_item();
        int pick;
        t_cmd c;
        logic [INDEX_BITS-1:0] idx;
        logic [PERIOD_W-1:0] per;
        pick = $urandom_range(99);
        if (pick < 45)      c = CMD_TICK;
        else if (pick < 60) c = CMD_CONFIGURE;
        else if (pick < 74) c = CMD_START;
        else if (pick < 80) c = CMD_STOP;
        else if (pick < 84) c = CMD_DEINIT;
        else if (pick < 90) c = CMD_CLEAR_FLAG;
        else if (pick < 98) c = CMD_QUERY;
        else                c = CMD_DEINIT_ALL;
        // Most commands land on a handful of timers, so that a configure is
        // usually followed by a start and ticks on the same timer.
        if ($urandom_range(9) < 7) idx = INDEX_BITS'($urandom_range(3));
        else                       idx = INDEX_BITS'($urandom_range(15));
        pick = $urandom_range(9);
        if (pick < 7)      per = PERIOD_W'($urandom_range(6, 1));
        else if (pick < 9) per = PERIOD_W'($urandom());
        else               per = '0;
        send_item(c, idx, per, 1'($urandom_range(1)));
    endtask

    task automatic send_random_items(int count);
        repeat (count) send_random_item();
    endtask

    // Lowers valid at the next falling edge and waits until every result
    // that is owed has been taken. Since every item yields a result, the
    // block is then idle.
    task automatic drain_outstanding();
        @(negedge i_clk);
        cmd_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // The prescale limit is only ever changed while the bank is idle.
    task automatic write_limit(logic [PRESC_BITS-1:0] value);
        drain_outstanding();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_idling(int sender_pct, int receiver_pct);
        sender_idle_pct = sender_pct;
        stall_pct       = receiver_pct;
    endtask

    // Result side. Ready changes only at the falling edge. A pending hold-off
    // takes priority over the random stalls and is counted down here, cycle
    // by cycle, while the stimulus keeps offering items.
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                res_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                res_ch.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        cmd_ch.valid           = 1'b0;
        cmd_ch.cmd             = CMD_TICK;
        cmd_ch.timer_index     = '0;
        cmd_ch.period          = '0;
        cmd_ch.callback_enable = 1'b0;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. With a limit of one every tick runs a countdown pass,
        // which keeps the special cases short.
        write_limit(8'd1);
        set_idling(0, 0);
        send_item(CMD_QUERY,      4'd0,  16'd0,     1'b0);
        // A one-pass timer with its interrupt enabled expires on the first tick.
        send_item(CMD_CONFIGURE,  4'd0,  16'd1,     1'b1);
        send_item(CMD_START,      4'd0,  16'd0,     1'b0);
        send_item(CMD_TICK,       4'd0,  16'd0,     1'b0);
        // Once at zero it stays there, and the flag stays set until cleared.
        send_item(CMD_TICK,       4'd0,  16'd0,     1'b0);
        send_item(CMD_CLEAR_FLAG, 4'd0,  16'd0,     1'b0);
        // The longest period on the highest timer, stopped after one pass.
        send_item(CMD_CONFIGURE,  4'd15, 16'hFFFF,  1'b0);
        send_item(CMD_START,      4'd15, 16'hFFFF,  1'b1);
        send_item(CMD_TICK,       4'd15, 16'd0,     1'b0);
        send_item(CMD_STOP,       4'd15, 16'd0,     1'b0);
        send_item(CMD_TICK,       4'd15, 16'd0,     1'b0);
        // Expiry without an interrupt, then a reload and a deinit.
        send_item(CMD_CONFIGURE,  4'd3,  16'd2,     1'b0);
        send_item(CMD_START,      4'd3,  16'd0,     1'b0);
        send_item(CMD_TICK,       4'd3,  16'd0,     1'b0);
        send_item(CMD_TICK,       4'd3,  16'd0,     1'b0);
        send_item(CMD_START,      4'd3,  16'd0,     1'b0);
        send_item(CMD_DEINIT,     4'd3,  16'd0,     1'b0);
        send_item(CMD_TICK,       4'd3,  16'd0,     1'b0);
        // A period of zero leaves the timer inactive even after a start.
        send_item(CMD_CONFIGURE,  4'd5,  16'd0,     1'b1);
        send_item(CMD_START,      4'd5,  16'd0,     1'b0);
        send_item(CMD_TICK,       4'd5,  16'd0,     1'b0);
        // Reconfiguring keeps the remaining count: parked while the period is
        // zero, it resumes once a nonzero period is stored again.
        send_item(CMD_CONFIGURE,  4'd8,  16'd4,     1'b1);
        send_item(CMD_START,      4'd8,  16'd0,     1'b0);
        send_item(CMD_CONFIGURE,  4'd8,  16'd0,     1'b1);
        send_item(CMD_TICK,       4'd8,  16'd0,     1'b0);
        send_item(CMD_CONFIGURE,  4'd8,  16'd2,     1'b1);
        send_item(CMD_TICK,       4'd8,  16'd0,     1'b0);
        // Deinit all clears the flag of an expired timer.
        send_item(CMD_CONFIGURE,  4'd7,  16'd1,     1'b1);
        send_item(CMD_START,      4'd7,  16'd0,     1'b0);
        send_item(CMD_TICK,       4'd7,  16'd0,     1'b0);
        send_item(CMD_DEINIT_ALL, 4'd7,  16'hFFFF,  1'b1);
        send_item(CMD_QUERY,      4'd7,  16'd0,     1'b0);

        // Random phases, each under its own limit and traffic pattern.
        write_limit(8'd3);
        set_idling(0, 0);
        send_random_items(25);

        write_limit(8'd1);
        set_idling(64, 0);
        send_random_items(25);

        write_limit(8'd2);
        set_idling(0, 64);
        send_random_items(25);

        // A limit of zero must behave like a limit of one.
        write_limit(8'd0);
        set_idling(24, 24);
        send_random_items(20);

        // Back-pressure: the result side holds off for a long stretch while
        // items keep coming, so the output register fills and input stalls.
        write_limit(8'd4);
        set_idling(0, 0);
        @(posedge i_clk);
        hold_left = HOLD_CYCLES;
        send_random_items(15);

        // Largest limit: a full run of ticks up to one pass, then the limit is
        // lowered below the count, which must cause a pass on the next tick.
        write_limit(8'd255);
        send_item(CMD_CONFIGURE, 4'd1, 16'd1, 1'b1);
        send_item(CMD_START,     4'd1, 16'd0, 1'b0);
        repeat (258) send_item(CMD_TICK, 4'd1, 16'd0, 1'b0);
        write_limit(8'd2);
        repeat (3) send_item(CMD_TICK, 4'd1, 16'd0, 1'b0);

        // Wind down with the result side always ready, then leave the bank
        // alone for a while so that any stray result is caught.
        set_idling(0, 0);
        drain_outstanding();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Checked %0d results, including %0d countdown passes and %0d timer expiries.",
                 checked, passes, expiries);
        $display("Prescale limits 0 to 255, input gaps, output stalls and a long hold-off.");
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

### sim.f
design/ostb_pkg.sv
design/ostb_in_if.sv
design/ostb_out_if.sv
design/ostb_ram.sv
design/ostb_step.sv
design/one_shot_timer_bank.sv
dv/timer_bank_check.sv
dv/tb.sv
